[rtl/core/c8_pkg.sv]
`timescale 1ns / 1ps
package c8_pkg;
    localparam int MemoryBytes  = 4096;
    localparam int ScreenHeight = 32;
    localparam int ScreenWidth  = 64;
    localparam int StackDepthDefault = 16;
    localparam logic [11:0] ProgramStart = 12'h200;
    localparam logic [11:0] FontBase     = 12'h050;
    localparam int FontBytes = 80;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;

    // major opcode nibbles
    localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SE_IMM = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4, OP_SE_REG = 4'h5, OP_LD_IMM = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7, OP_ALU = 4'h8, OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I = 4'hA, OP_JP_V0 = 4'hB, OP_RND = 4'hC, OP_DRW = 4'hD;
    localparam logic [3:0] OP_KEY = 4'hE, OP_MISC = 4'hF;
    localparam logic [15:0] OPC_CLS = 16'h00E0, OPC_RET = 16'h00EE;
    localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
    localparam logic [7:0] F_GET_DT = 8'h07, F_WAIT_KEY = 8'h0A, F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18, F_ADD_I = 8'h1E, F_FONT = 8'h29;
    localparam logic [7:0] F_BCD = 8'h33, F_SAVE = 8'h55, F_RESTORE = 8'h65;
    localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7, ALU_SHL = 4'hE;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_WAIT, ST_EXEC,
        ST_CLEAR, ST_DRAW_RD, ST_DRAW_WAIT, ST_DRAW_WR,
        ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WAIT, ST_LOAD_WR,
        ST_FINISH, ST_OUT
    } state_t;

    typedef struct packed {
        logic init_write;
        logic capture;
        logic do_load;
        logic fetch_hi;
        logic fetch_lo;
        logic latch_op;
        logic execute;
        logic clear_row;
        logic draw_read;
        logic draw_write;
        logic bcd_write;
        logic store_write;
        logic load_read;
        logic load_write;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [3:0] major;
        logic [3:0] n;
        logic [7:0] nn;
        logic [3:0] x;
        logic       step_last;
        logic       init_last;
        logic       draw_done;
        logic [1:0] kind;
    } status_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] g [0:79];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (i < 7'd80)
            return g[i];
        return 8'h00;
    endfunction
endpackage

[rtl/core/c8_if.sv]
`timescale 1ns / 1ps
interface c8_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] address;
    logic [7:0]  data;
    logic [4:0]  row;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    modport source (output valid, kind, address, data, row, keys, random_byte, input ready);
    modport sink (input valid, kind, address, data, row, keys, random_byte, output ready);
endinterface

interface c8_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] instruction;
    logic        draw_flag;
    logic        sound_on;
    logic        waiting_for_key;
    logic [63:0] row_pixels;
    modport source (output valid, program_counter, instruction, draw_flag, sound_on,
                    waiting_for_key, row_pixels, input ready);
    modport sink (input valid, program_counter, instruction, draw_flag, sound_on,
                  waiting_for_key, row_pixels, output ready);
endinterface

[rtl/core/c8_control.sv]
`timescale 1ns / 1ps
module c8_control
    import c8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_write = 1'b1;
                if (status.init_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_FETCH_HI;
            end
            ST_FETCH_HI:
            begin
                // decode the captured request kind
                case (status.kind)
                    KIND_STEP:
                    begin
                        cmd.fetch_hi = 1'b1;
                        state_next   = ST_FETCH_LO;
                    end
                    KIND_LOAD:
                    begin
                        cmd.do_load = 1'b1;
                        state_next  = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_FETCH_LO:
            begin
                cmd.fetch_lo = 1'b1;
                state_next   = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT:
            begin
                cmd.latch_op = 1'b1;
                state_next   = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_FINISH;
                if ({status.major, status.x, status.nn} == OPC_CLS)
                    state_next = ST_CLEAR;
                else if (status.major == OP_DRW)
                    state_next = (status.n == 4'h0) ? ST_FINISH : ST_DRAW_RD;
                else if (status.major == OP_MISC && status.nn == F_BCD)
                    state_next = ST_BCD;
                else if (status.major == OP_MISC && status.nn == F_SAVE)
                    state_next = ST_STORE;
                else if (status.major == OP_MISC && status.nn == F_RESTORE)
                    state_next = ST_LOAD_RD;
            end
            ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (status.step_last)
                    state_next = ST_FINISH;
            end
            ST_DRAW_RD:
            begin
                cmd.draw_read = 1'b1;
                state_next    = status.draw_done ? ST_FINISH : ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: state_next = ST_DRAW_WR;
            ST_DRAW_WR:
            begin
                cmd.draw_write = 1'b1;
                state_next     = ST_DRAW_RD;
            end
            ST_BCD:
            begin
                cmd.bcd_write = 1'b1;
                if (status.step_last)
                    state_next = ST_FINISH;
            end
            ST_STORE:
            begin
                cmd.store_write = 1'b1;
                if (status.step_last)
                    state_next = ST_FINISH;
            end
            ST_LOAD_RD:
            begin
                cmd.load_read = 1'b1;
                state_next    = ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT: state_next = ST_LOAD_WR;
            ST_LOAD_WR:
            begin
                cmd.load_write = 1'b1;
                state_next     = status.step_last ? ST_FINISH : ST_LOAD_RD;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_single_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !in_ready) else $error("output load while idle");
    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid) else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("accept while busy");
endmodule

[rtl/core/c8_datapath.sv]
`timescale 1ns / 1ps
module c8_datapath
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  kind,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [4:0]  row,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    output logic [11:0] program_counter,
    output logic [15:0] instruction,
    output logic        draw_flag,
    output logic        sound_on,
    output logic        waiting_for_key,
    output logic [63:0] row_pixels
);
    localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]  mem [0:MemoryBytes-1];
    logic [63:0] disp [0:ScreenHeight-1];
    logic [11:0] stack [0:STACK_DEPTH-1];
    logic [7:0]  v_reg [0:15];

    logic [11:0] mem_addr;
    logic [7:0]  mem_rdata_reg;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    logic [1:0]  kind_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [4:0]  row_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [15:0] op_reg;
    logic [11:0] pc_reg, i_reg;
    logic [SpW-1:0] sp_reg, sp_dec;
    logic [7:0]  dt_reg, st_reg;
    logic [6:0]  cnt_reg;
    logic [11:0] init_cnt_reg, font_off;
    logic [4:0]  dy_reg;
    logic [5:0]  dx_reg;
    logic        hit_reg, drew_reg, wait_reg;
    logic [63:0] line_reg;
    logic [7:0]  bcd_h, bcd_t, bcd_o;

    // out register
    logic [11:0] out_pc_reg;
    logic [15:0] out_op_reg;
    logic        out_draw_reg, out_snd_reg, out_wait_reg;
    logic [63:0] out_pix_reg;

    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, pc2;
    logic [63:0] mask;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx  = v_reg[x];
    assign vy  = v_reg[y];
    assign pc2 = pc_reg + 12'd2;
    assign mask = {mem_rdata_reg, 56'd0} >> dx_reg;
    assign font_off = init_cnt_reg - FontBase;
    // stack pointer wraps modulo the depth in both directions
    assign sp_dec = (sp_reg == '0) ? SpW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    assign bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    always_comb
    begin
        logic [7:0] r;
        r = vx - bcd_h * 8'd100;
        bcd_t = 8'd0;
        for (int k = 9; k >= 1; k--)
            if (bcd_t == 8'd0 && r >= 8'(k * 10))
                bcd_t = 8'(k);
        bcd_o = r - bcd_t * 8'd10;
    end

    assign status.major     = op_reg[15:12];
    assign status.n         = n;
    assign status.nn        = nn;
    assign status.x         = x;
    assign status.kind      = kind_reg;
    assign status.init_last = (init_cnt_reg == 12'(MemoryBytes - 1));
    assign status.step_last = cmd.clear_row ? (cnt_reg == 7'(ScreenHeight - 1))
                            : cmd.bcd_write ? (cnt_reg == 7'd2)
                            : (cnt_reg[3:0] == x);
    assign status.draw_done = (cnt_reg[3:0] == n) || (dy_reg + 5'(cnt_reg) < dy_reg)
                            || ({1'b0, dy_reg} + {2'b0, cnt_reg[3:0]} > 6'd31);

    // single memory port mux
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 8'd0;
        mem_addr  = i_reg + 12'(cnt_reg);
        if (cmd.init_write)
        begin
            mem_we = 1'b1;
            mem_addr = init_cnt_reg;
            if (init_cnt_reg >= FontBase && init_cnt_reg < FontBase + 12'(FontBytes))
                mem_wdata = font_byte(font_off[6:0]);
        end
        else if (cmd.do_load)
        begin
            mem_we = 1'b1;
            mem_addr = addr_reg;
            mem_wdata = data_reg;
        end
        else if (cmd.fetch_hi)
            mem_addr = pc_reg;
        else if (cmd.fetch_lo)
            mem_addr = pc_reg + 12'd1;
        else if (cmd.bcd_write)
        begin
            mem_we = 1'b1;
            mem_wdata = (cnt_reg == 7'd0) ? bcd_h : (cnt_reg == 7'd1) ? bcd_t : bcd_o;
        end
        else if (cmd.store_write)
        begin
            mem_we = 1'b1;
            mem_wdata = v_reg[cnt_reg[3:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    // the init sweep after reset clears every byte and lays down the font

    logic [7:0] op_hold_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= address;
            data_reg <= data;
            row_reg  <= row;
            keys_reg <= keys;
            rnd_reg  <= random_byte;
        end
        if (cmd.fetch_lo)
            op_hold_reg <= mem_rdata_reg;
        line_reg <= disp[dy_reg + 5'(cnt_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_LOAD;
            op_reg   <= '0;
            pc_reg   <= ProgramStart;
            i_reg    <= '0;
            sp_reg   <= '0;
            dt_reg   <= '0;
            st_reg   <= '0;
            cnt_reg  <= '0;
            init_cnt_reg <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
            hit_reg  <= 1'b0;
            drew_reg <= 1'b0;
            wait_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
                v_reg[k] <= '0;
            for (int k = 0; k < STACK_DEPTH; k++)
                stack[k] <= '0;
            for (int k = 0; k < ScreenHeight; k++)
                disp[k] <= '0;
            out_pc_reg   <= ProgramStart;
            out_op_reg   <= '0;
            out_draw_reg <= 1'b0;
            out_snd_reg  <= 1'b0;
            out_wait_reg <= 1'b0;
            out_pix_reg  <= '0;
        end
        else
        begin
            if (cmd.init_write)
                init_cnt_reg <= init_cnt_reg + 12'd1;
            if (cmd.capture)
            begin
                kind_reg <= kind;
                op_reg   <= '0;
                drew_reg <= 1'b0;
                wait_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            if (cmd.latch_op)
                op_reg <= {op_hold_reg, mem_rdata_reg};
            if (cmd.execute)
            begin
                pc_reg  <= pc2;
                cnt_reg <= '0;
                case (op_reg[15:12])
                    OP_SYS:
                    begin
                        if (op_reg == OPC_CLS)
                            drew_reg <= 1'b1;
                        else if (op_reg == OPC_RET)
                        begin
                            sp_reg <= sp_dec;
                            pc_reg <= stack[sp_dec];
                        end
                    end
                    OP_JP: pc_reg <= nnn;
                    OP_CALL:
                    begin
                        stack[sp_reg] <= pc2;
                        sp_reg <= (STACK_DEPTH == (1 << SpW)) ? sp_reg + 1'b1
                                : ((32'(sp_reg) == STACK_DEPTH - 1) ? '0 : sp_reg + 1'b1);
                        pc_reg <= nnn;
                    end
                    OP_SE_IMM: if (vx == nn) pc_reg <= pc2 + 12'd2;
                    OP_SNE_IMM: if (vx != nn) pc_reg <= pc2 + 12'd2;
                    OP_SE_REG: if (n == 4'h0 && vx == vy) pc_reg <= pc2 + 12'd2;
                    OP_LD_IMM: v_reg[x] <= nn;
                    OP_ADD_IMM: v_reg[x] <= vx + nn;
                    OP_ALU:
                    begin
                        case (n)
                            ALU_MOV: v_reg[x] <= vy;
                            ALU_OR: v_reg[x] <= vx | vy;
                            ALU_AND: v_reg[x] <= vx & vy;
                            ALU_XOR: v_reg[x] <= vx ^ vy;
                            ALU_ADD:
                            begin
                                v_reg[x]  <= vx + vy;
                                v_reg[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                            end
                            ALU_SUB:
                            begin
                                v_reg[x]  <= vx - vy;
                                v_reg[15] <= {7'd0, vx >= vy};
                            end
                            ALU_SHR:
                            begin
                                v_reg[x]  <= vx >> 1;
                                v_reg[15] <= {7'd0, vx[0]};
                            end
                            ALU_SUBN:
                            begin
                                v_reg[x]  <= vy - vx;
                                v_reg[15] <= {7'd0, vy >= vx};
                            end
                            ALU_SHL:
                            begin
                                v_reg[x]  <= vx << 1;
                                v_reg[15] <= {7'd0, vx[7]};
                            end
                            default: ;
                        endcase
                    end
                    OP_SNE_REG: if (n == 4'h0 && vx != vy) pc_reg <= pc2 + 12'd2;
                    OP_LD_I: i_reg <= nnn;
                    OP_JP_V0: pc_reg <= nnn + {4'd0, v_reg[0]};
                    OP_RND: v_reg[x] <= rnd_reg & nn;
                    OP_DRW:
                    begin
                        dx_reg   <= vx[5:0];
                        dy_reg   <= vy[4:0];
                        hit_reg  <= 1'b0;
                        drew_reg <= 1'b1;
                        if (n == 4'h0)
                            v_reg[15] <= 8'd0;
                    end
                    OP_KEY:
                    begin
                        if (nn == KEY_DOWN && vx[7:4] == 4'd0 && keys_reg[vx[3:0]])
                            pc_reg <= pc2 + 12'd2;
                        else if (nn == KEY_UP && !(vx[7:4] == 4'd0 && keys_reg[vx[3:0]]))
                            pc_reg <= pc2 + 12'd2;
                    end
                    OP_MISC:
                    begin
                        case (nn)
                            F_GET_DT: v_reg[x] <= dt_reg;
                            F_WAIT_KEY:
                            begin
                                if (keys_reg == 16'd0)
                                begin
                                    pc_reg   <= pc_reg;
                                    wait_reg <= 1'b1;
                                end
                                else
                                begin
                                    v_reg[x] <= 8'd15;
                                    for (int k = 14; k >= 0; k--)
                                        if (keys_reg[k])
                                            v_reg[x] <= 8'(k);
                                end
                            end
                            F_SET_DT: dt_reg <= vx;
                            F_SET_ST: st_reg <= vx;
                            F_ADD_I: i_reg <= i_reg + {4'd0, vx};
                            F_FONT: i_reg <= FontBase + {6'd0, vx[3:0], 2'b0} + {8'd0, vx[3:0]};
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (cmd.clear_row)
            begin
                disp[cnt_reg[4:0]] <= '0;
                cnt_reg <= cnt_reg + 7'd1;
            end
            if (cmd.bcd_write || cmd.store_write)
                cnt_reg <= cnt_reg + 7'd1;
            if (cmd.draw_read && status.draw_done)
                v_reg[15] <= {7'd0, hit_reg};
            if (cmd.draw_write)
            begin
                if ((line_reg & mask) != 64'd0)
                    hit_reg <= 1'b1;
                disp[dy_reg + 5'(cnt_reg)] <= line_reg ^ mask;
                cnt_reg <= cnt_reg + 7'd1;
            end
            if (cmd.load_write)
            begin
                v_reg[cnt_reg[3:0]] <= mem_rdata_reg;
                cnt_reg <= cnt_reg + 7'd1;
            end
            if (cmd.finish)
            begin
                if (dt_reg != 8'd0)
                    dt_reg <= dt_reg - 8'd1;
                if (st_reg != 8'd0)
                    st_reg <= st_reg - 8'd1;
            end
            if (cmd.out_load)
            begin
                out_pc_reg   <= pc_reg;
                out_op_reg   <= op_reg;
                out_draw_reg <= drew_reg;
                out_snd_reg  <= (st_reg != 8'd0);
                out_wait_reg <= wait_reg;
                out_pix_reg  <= (kind_reg == KIND_ROW) ? disp[row_reg] : 64'd0;
            end
        end
    end

    assign program_counter = out_pc_reg;
    assign instruction     = out_op_reg;
    assign draw_flag       = out_draw_reg;
    assign sound_on        = out_snd_reg;
    assign waiting_for_key = out_wait_reg;
    assign row_pixels      = out_pix_reg;

    a_pc_even_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch_hi |=> cmd.fetch_lo) else $error("fetch split");
    a_draw_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg[15:12] == OP_DRW) |=> drew_reg) else $error("draw flag");
    a_wait_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_reg[15:0] == {OP_MISC, x, F_WAIT_KEY} && keys_reg == 16'd0)
        |=> $stable(pc_reg)) else $error("key wait moved pc");
endmodule

[rtl/core/chip8_instruction_core.sv]
`timescale 1ns / 1ps
// chip-8 instruction core
// request channel req (kind, address, data, row, keys, random_byte) and
// response channel rsp; both valid/ready, one response per request, in order.
// after reset an init sweep over all 4096 bytes clears main memory and writes the
// font at 0x050; no request is taken until it ends, and pc starts at 0x200.
// a load or row request passes from idle through the decode state to output.
// a step request fetches both opcode bytes and executes, then a display clear
// sweeps every row, a draw reads and rewrites each visible sprite row, bcd writes
// three digits, and register store and load move v0..vx one byte at a time
// through the single-port main memory. one request is in flight at a time; the
// core is ready for the next request in the same cycle the response is presented.
// the response sits in an output register; if the receiver stalls, the core can
// take one more request but holds its result until the response register frees.
module chip8_instruction_core
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
)
(
    input logic  clk,
    input logic  rst_n,
    c8_in_if.sink    req,
    c8_out_if.source rsp
);
    cmd_t    cmd;
    status_t status;

    c8_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    c8_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .kind            (req.kind),
        .address         (req.address),
        .data            (req.data),
        .row             (req.row),
        .keys            (req.keys),
        .random_byte     (req.random_byte),
        .program_counter (rsp.program_counter),
        .instruction     (rsp.instruction),
        .draw_flag       (rsp.draw_flag),
        .sound_on        (rsp.sound_on),
        .waiting_for_key (rsp.waiting_for_key),
        .row_pixels      (rsp.row_pixels)
    );
endmodule

[test/chip8_instruction_core_test.sv]
`timescale 1ns / 1ps
module chip8_instruction_core_test;
    import c8_pkg::*;

    localparam int TOTAL_REQUESTS = 550;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] op;
        logic        drew;
        logic        sound;
        logic        waiting;
        logic [63:0] pixels;
    } core_result_t;

    class core_scoreboard;
        logic [7:0]  mem [0:4095];
        logic [63:0] screen [0:31];
        logic [7:0]  v [0:15];
        logic [11:0] stack [0:15];
        logic [3:0]  sp;
        logic [11:0] ireg;
        logic [11:0] pc;
        logic [7:0]  dly_count;
        logic [7:0]  snd_count;
        core_result_t pending [$];
        int errors;

        function void clear_state();
            logic [7:0] glyph [0:79];
            glyph = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
                      8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
                      8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
                      8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
                      8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
                      8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
                      8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
                      8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < 80; i++) mem[FontBase + i] = glyph[i];
            foreach (screen[i]) screen[i] = '0;
            foreach (v[i]) v[i] = '0;
            foreach (stack[i]) stack[i] = '0;
            sp = '0;
            ireg = '0;
            pc = ProgramStart;
            dly_count = '0;
            snd_count = '0;
            errors = 0;
        endfunction

        function void execute(input logic [15:0] keys, input logic [7:0] rnd,
                              output logic drew, output logic waiting);
            logic [15:0] op;
            logic [3:0]  x, y, n;
            logic [7:0]  nn, a, b, f;
            logic [63:0] mask;
            logic [5:0]  px;
            logic [4:0]  py;
            logic        hit;
            logic [4:0]  k;
            op = {mem[pc], mem[pc + 12'd1]};
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            nn = op[7:0];
            drew = 1'b0;
            waiting = 1'b0;
            pc = pc + 12'd2;
            case (op[15:12])
                OP_SYS:
                begin
                    if (op == OPC_CLS)
                    begin
                        foreach (screen[i]) screen[i] = '0;
                        drew = 1'b1;
                    end
                    else if (op == OPC_RET)
                    begin
                        sp = sp - 4'd1;
                        pc = stack[sp];
                    end
                end
                OP_JP: pc = op[11:0];
                OP_CALL:
                begin
                    stack[sp] = pc;
                    sp = sp + 4'd1;
                    pc = op[11:0];
                end
                OP_SE_IMM: if (v[x] == nn) pc = pc + 12'd2;
                OP_SNE_IMM: if (v[x] != nn) pc = pc + 12'd2;
                OP_SE_REG: if (n == 4'h0 && v[x] == v[y]) pc = pc + 12'd2;
                OP_LD_IMM: v[x] = nn;
                OP_ADD_IMM: v[x] = v[x] + nn;
                OP_ALU:
                begin
                    a = v[x];
                    b = v[y];
                    case (n)
                        ALU_MOV: v[x] = b;
                        ALU_OR: v[x] = a | b;
                        ALU_AND: v[x] = a & b;
                        ALU_XOR: v[x] = a ^ b;
                        ALU_ADD:
                        begin
                            f = ({1'b0, a} + {1'b0, b}) > 9'd255;
                            v[x] = a + b;
                            v[15] = f;
                        end
                        ALU_SUB:
                        begin
                            f = a >= b;
                            v[x] = a - b;
                            v[15] = f;
                        end
                        ALU_SHR:
                        begin
                            f = a[0];
                            v[x] = a >> 1;
                            v[15] = f;
                        end
                        ALU_SUBN:
                        begin
                            f = b >= a;
                            v[x] = b - a;
                            v[15] = f;
                        end
                        ALU_SHL:
                        begin
                            f = a[7];
                            v[x] = a << 1;
                            v[15] = f;
                        end
                        default: ;
                    endcase
                end
                OP_SNE_REG: if (n == 4'h0 && v[x] != v[y]) pc = pc + 12'd2;
                OP_LD_I: ireg = op[11:0];
                OP_JP_V0: pc = op[11:0] + {4'h0, v[0]};
                OP_RND: v[x] = rnd & nn;
                OP_DRW:
                begin
                    px = v[x][5:0];
                    py = v[y][4:0];
                    hit = 1'b0;
                    for (int i = 0; i < n && py + i < 32; i++)
                    begin
                        mask = {mem[ireg + i[11:0]], 56'h0} >> px;
                        if ((screen[py + i] & mask) != 0) hit = 1'b1;
                        screen[py + i] = screen[py + i] ^ mask;
                    end
                    v[15] = {7'h0, hit};
                    drew = 1'b1;
                end
                OP_KEY:
                begin
                    if (nn == KEY_DOWN)
                    begin
                        if (v[x] < 16 && keys[v[x][3:0]]) pc = pc + 12'd2;
                    end
                    else if (nn == KEY_UP)
                    begin
                        if (!(v[x] < 16 && keys[v[x][3:0]])) pc = pc + 12'd2;
                    end
                end
                OP_MISC:
                begin
                    case (nn)
                        F_GET_DT: v[x] = dly_count;
                        F_WAIT_KEY:
                        begin
                            if (keys == 16'h0)
                            begin
                                pc = pc - 12'd2;
                                waiting = 1'b1;
                            end
                            else
                            begin
                                k = 5'd0;
                                while (k < 15 && !keys[k[3:0]]) k = k + 5'd1;
                                v[x] = {3'b0, k};
                            end
                        end
                        F_SET_DT: dly_count = v[x];
                        F_SET_ST: snd_count = v[x];
                        F_ADD_I: ireg = ireg + {4'h0, v[x]};
                        F_FONT: ireg = FontBase + 12'd5 * {8'h0, v[x][3:0]};
                        F_BCD:
                        begin
                            mem[ireg] = v[x] / 100;
                            mem[ireg + 12'd1] = (v[x] / 10) % 10;
                            mem[ireg + 12'd2] = v[x] % 10;
                        end
                        F_SAVE: for (int i = 0; i <= x; i++) mem[ireg + i[11:0]] = v[i];
                        F_RESTORE: for (int i = 0; i <= x; i++) v[i] = mem[ireg + i[11:0]];
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (dly_count != 0) dly_count = dly_count - 8'd1;
            if (snd_count != 0) snd_count = snd_count - 8'd1;
        endfunction

        function void note_request(input logic [1:0] kind, input logic [11:0] address,
                                   input logic [7:0] data, input logic [4:0] row,
                                   input logic [15:0] keys, input logic [7:0] rnd);
            core_result_t r;
            logic d, w;
            r = '0;
            if (kind == KIND_LOAD)
                mem[address] = data;
            else if (kind == KIND_ROW)
                r.pixels = screen[row];
            else if (kind == KIND_STEP)
            begin
                r.op = {mem[pc], mem[pc + 12'd1]};
                execute(keys, rnd, d, w);
                r.drew = d;
                r.waiting = w;
            end
            r.pc = pc;
            r.sound = snd_count != 0;
            pending.push_back(r);
        endfunction

        function void check_response(input core_result_t got);
            core_result_t want;
            if (pending.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.pc !== want.pc)
            begin
                $error("program_counter expected %h actual %h", want.pc, got.pc);
                errors++;
            end
            if (got.op !== want.op)
            begin
                $error("instruction expected %h actual %h", want.op, got.op);
                errors++;
            end
            if (got.drew !== want.drew)
            begin
                $error("draw_flag expected %b actual %b", want.drew, got.drew);
                errors++;
            end
            if (got.sound !== want.sound)
            begin
                $error("sound_on expected %b actual %b", want.sound, got.sound);
                errors++;
            end
            if (got.waiting !== want.waiting)
            begin
                $error("waiting_for_key expected %b actual %b", want.waiting, got.waiting);
                errors++;
            end
            if (got.pixels !== want.pixels)
            begin
                $error("row_pixels expected %h actual %h", want.pixels, got.pixels);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    core_scoreboard sb;

    c8_in_if  req ();
    c8_out_if rsp ();

    chip8_instruction_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("chip8_instruction_core_test NOT OK");
        $finish;
    end

    always @(negedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response({rsp.program_counter, rsp.instruction, rsp.draw_flag,
                               rsp.sound_on, rsp.waiting_for_key, rsp.row_pixels});

    task automatic send_request(input logic [1:0] kind, input logic [11:0] address,
                                input logic [7:0] data, input logic [4:0] row,
                                input logic [15:0] keys, input logic [7:0] rnd);
        req.valid = 1'b1;
        req.kind = kind;
        req.address = address;
        req.data = data;
        req.row = row;
        req.keys = keys;
        req.random_byte = rnd;
        do @(posedge clk); while (!req.ready);
        sb.note_request(kind, address, data, row, keys, rnd);
        sent++;
        if (sent < TOTAL_REQUESTS / 3)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 65;
        end
        else if (sent < 2 * TOTAL_REQUESTS / 3)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic load_word(input logic [11:0] address, input logic [15:0] op);
        send_request(KIND_LOAD, address, op[15:8], 5'($urandom), 16'($urandom), 8'($urandom));
        send_request(KIND_LOAD, address + 12'd1, op[7:0], 5'($urandom), 16'($urandom),
                     8'($urandom));
    endtask

    task automatic step(input logic [15:0] keys);
        send_request(KIND_STEP, 12'($urandom), 8'($urandom), 5'($urandom), keys, 8'($urandom));
    endtask

    function automatic logic [15:0] random_opcode(input logic [11:0] here);
        logic [3:0] major;
        logic [15:0] op;
        logic [7:0] pick [0:9];
        logic [3:0] alu [0:9];
        pick = '{F_GET_DT, F_WAIT_KEY, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT, F_BCD,
                 F_SAVE, F_RESTORE, 8'($urandom)};
        alu = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
                ALU_SHL, 4'($urandom)};
        major = 4'($urandom);
        op = {major, 12'($urandom)};
        case (major)
            OP_SYS:
                case ($urandom_range(0, 3))
                    0: op = OPC_CLS;
                    1, 2: op = OPC_RET;
                    default: ;
                endcase
            // keep most jumps near the loaded code
            OP_JP, OP_CALL, OP_JP_V0:
                if ($urandom_range(0, 3) != 0)
                    op[11:0] = here + 12'($urandom_range(0, 24)) * 12'd2;
            OP_SE_REG, OP_SNE_REG: if ($urandom_range(0, 3) != 0) op[3:0] = 4'h0;
            OP_ALU: op[3:0] = alu[$urandom_range(0, 9)];
            OP_KEY:
                if ($urandom_range(0, 4) != 0)
                    op[7:0] = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
            OP_MISC: op[7:0] = pick[$urandom_range(0, 9)];
            OP_DRW: if ($urandom_range(0, 3) == 0) op[3:0] = 4'hF;
            default: ;
        endcase
        return op;
    endfunction

    function automatic logic [15:0] random_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0;
            1: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [11:0] base;
        int n;
        sb = new();
        sb.clear_state();
        sent = 0;
        send_idle_pct = 34;
        recv_idle_pct = 65;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_LOAD;
        req.address = '0;
        req.data = '0;
        req.row = '0;
        req.keys = '0;
        req.random_byte = '0;
        rsp.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clear, sprite clipped at the bottom right corner, redraw for collision, key wait
        send_request(KIND_LOAD, 12'hFFF, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF);
        load_word(12'h200, OPC_CLS);
        load_word(12'h202, 16'h613C);
        load_word(12'h204, 16'h621E);
        load_word(12'h206, 16'hA050);
        load_word(12'h208, 16'hD125);
        load_word(12'h20A, 16'hD125);
        load_word(12'h20C, 16'hF00A);
        for (int i = 0; i < 5; i++) step(16'h0);
        send_request(KIND_ROW, 12'h0, 8'h0, 5'd30, 16'h0, 8'h0);
        step(16'h0);
        step(16'h0);
        step(16'h8000);
        send_request(KIND_ROW, 12'h0, 8'h0, 5'd31, 16'h0, 8'h0);

        while (sent < TOTAL_REQUESTS)
        begin
            base = sb.pc;
            n = $urandom_range(2, 10);
            for (int i = 0; i < n; i++)
                load_word(base + 12'(i * 2), random_opcode(base));
            if ($urandom_range(0, 4) == 0)
                send_request(KIND_LOAD, 12'($urandom), 8'($urandom), 5'($urandom),
                             16'($urandom), 8'($urandom));
            for (int i = 0; i < n + 2; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_request(KIND_ROW, 12'($urandom), 8'($urandom), 5'($urandom),
                                 16'($urandom), 8'($urandom));
                else
                    step(random_keys());
            end
        end
        req.valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("chip8_instruction_core_test OK");
        else
            $display("chip8_instruction_core_test NOT OK");
        $finish;
    end
endmodule
